[src/signed_unsigned_divider_64_defines.svh]
// Assertion macros for the signed/unsigned divider.
// No dependencies; modules that use these must have i_clk and i_rst_n.
`ifndef SIGNED_UNSIGNED_DIVIDER_64_DEFINES_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SUD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SUD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/sud64_pkg.sv]
// Shared types and constants for the signed/unsigned divider.
// No dependencies.
`default_nettype none

package sud64_pkg;

    localparam int DATA_W = 64;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // Control word carried down the cell chain alongside the data.
    typedef struct packed {
        logic valid;
        logic neg_q;
        logic neg_r;
    } t_ctl;

endpackage

`default_nettype wire

[src/sud64_prep.sv]
// Operand conditioning: takes magnitudes for signed words, records result signs.
// Depends on sud64_pkg.
`default_nettype none

module sud64_prep
    import sud64_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_operation,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output t_ctl                   o_ctl,
    output logic [W-1:0]           o_dq,
    output logic [W-1:0]           o_div
);

    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         a_neg;
    logic         b_neg;
    logic [W-1:0] n_dq;
    logic [W-1:0] n_div;
    t_ctl         n_ctl;
    t_ctl         r_ctl;
    logic [W-1:0] r_dq;
    logic [W-1:0] r_div;

    always_comb begin
        a     = i_dividend[W-1:0];
        b     = i_divisor[W-1:0];
        a_neg = (i_operation == OP_SIGNED) && a[W-1];
        b_neg = (i_operation == OP_SIGNED) && b[W-1];
        n_dq  = a_neg ? (~a + W'(1)) : a;
        n_div = b_neg ? (~b + W'(1)) : b;
        n_ctl.valid = i_valid;
        n_ctl.neg_q = a_neg ^ b_neg;
        n_ctl.neg_r = a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq  <= n_dq;
        r_div <= n_div;
    end

    assign o_ctl = r_ctl;
    assign o_dq  = r_dq;
    assign o_div = r_div;

endmodule

`default_nettype wire

[src/sud64_cell.sv]
// One restoring division step: shift in a dividend bit, subtract if it fits.
// Depends on sud64_pkg and the assertion macro header.
`default_nettype none
`include "signed_unsigned_divider_64_defines.svh"

module sud64_cell
    import sud64_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_ctl         i_ctl,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_dq,   // dividend bits on top, quotient bits below
    input  wire logic [W-1:0] i_div,
    output t_ctl              o_ctl,
    output logic [W-1:0]      o_rem,
    output logic [W-1:0]      o_dq,
    output logic [W-1:0]      o_div
);

    logic [W:0]   shifted;
    logic [W+1:0] diff;
    logic         fits;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_dq;
    t_ctl         r_ctl;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_dq;
    logic [W-1:0] r_div;

    always_comb begin
        shifted = {i_rem, i_dq[W-1]};
        diff    = {1'b0, shifted} - {2'b00, i_div};
        fits    = !diff[W+1];
        n_rem   = fits ? diff[W-1:0] : shifted[W-1:0];
        n_dq    = {i_dq[W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_div <= i_div;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_dq  = r_dq;
    assign o_div = r_div;

    `SUD_ASSERT_IMP(a_rem_below_div, r_ctl.valid && (r_div != '0), r_rem < r_div, "partial remainder not below divisor")
    `SUD_ASSERT_NXT(a_zero_div_sets_bit, i_ctl.valid && (i_div == '0), r_dq[0], "zero divisor must set quotient bit")

endmodule

`default_nettype wire

[src/sud64_post.sv]
// Result sign fix-up and output register.
// Depends on sud64_pkg.
`default_nettype none

module sud64_post
    import sud64_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_ctl         i_ctl,
    input  wire logic [W-1:0] i_quo,
    input  wire logic [W-1:0] i_rem,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient,
    output logic [DATA_W-1:0] o_remainder
);

    logic [W-1:0] n_quo;
    logic [W-1:0] n_rem;
    logic         r_done;
    logic [W-1:0] r_quo;
    logic [W-1:0] r_rem;

    always_comb begin
        n_quo = i_ctl.neg_q ? (~i_quo + W'(1)) : i_quo;
        n_rem = i_ctl.neg_r ? (~i_rem + W'(1)) : i_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done      = r_done;
    assign o_quotient  = DATA_W'(r_quo);
    assign o_remainder = DATA_W'(r_rem);

endmodule

`default_nettype wire

[src/signed_unsigned_divider_64.sv]
// Pipelined signed/unsigned divider, W = 2*HALF_WIDTH bits, restoring algorithm.
// Registers in order: input register, one cell per quotient bit, output
// register. Throughput: one word per cycle.
// busy is always low; results are strobed once on o_done and cannot be stalled.
// Reset (i_rst_n low, synchronous) clears all valid flags; data regs hold junk.
// Depends on sud64_pkg, sud64_prep, sud64_cell, sud64_post and the macro header.
`default_nettype none
`include "signed_unsigned_divider_64_defines.svh"

module signed_unsigned_divider_64
    import sud64_pkg::*;
#(
    parameter int HALF_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_operation,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DATA_W-1:0]      o_quotient,
    output logic [DATA_W-1:0]      o_remainder
);

    localparam int W   = 2 * HALF_WIDTH;
    localparam int LAT = W + 2;

    // Stage k feeds cell k; stage W is the last cell's output.
    t_ctl         st_ctl [0:W];
    logic [W-1:0] st_rem [0:W];
    logic [W-1:0] st_dq  [0:W];
    logic [W-1:0] st_div [0:W];

    // The pipeline never stalls, so a new word is taken every cycle.
    assign busy = 1'b0;

    // Magnitudes and result signs are registered ahead of the chain.
    sud64_prep #(.W(W)) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start),
        .i_operation (i_operation),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_ctl       (st_ctl[0]),
        .o_dq        (st_dq[0]),
        .o_div       (st_div[0])
    );

    // Partial remainder starts at zero.
    assign st_rem[0] = '0;

    // One cell per quotient bit, MSB first. The dividend shifts out of the top
    // of dq while quotient bits shift into the bottom; after W cells dq holds
    // the quotient and rem the remainder magnitude.
    for (genvar k = 0; k < W; k++) begin : g_cell
        sud64_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (st_ctl[k]),
            .i_rem   (st_rem[k]),
            .i_dq    (st_dq[k]),
            .i_div   (st_div[k]),
            .o_ctl   (st_ctl[k+1]),
            .o_rem   (st_rem[k+1]),
            .o_dq    (st_dq[k+1]),
            .o_div   (st_div[k+1])
        );
    end

    // Sign fix-up and output register; upper bits above W read as zero.
    sud64_post #(.W(W)) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (st_ctl[W]),
        .i_quo       (st_dq[W]),
        .i_rem       (st_rem[W]),
        .o_done      (o_done),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

    // Every strobe traces back to an earlier start through the prep, cell and post registers.
    `SUD_ASSERT_IMP(a_done_has_start, o_done, $past(start, LAT), "result strobe without matching start")

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined signed/unsigned 64-bit divider.
// Depends on sud64_pkg and the signed_unsigned_divider_64 RTL; reads no files.
`default_nettype none

module tb_top
    import sud64_pkg::*;
();

    // Geometry and timing. The divider registers each word from the accepting edge
    // to its o_done strobe, and it never stalls its input (busy stays low).
    localparam int HALF_W     = 32;
    localparam int WORD_W     = 2 * HALF_W;
    localparam int LATENCY    = WORD_W + 2;
    localparam int CLK_HALF   = 4;
    localparam int RST_CYCLES = 11;
    localparam int N_RANDOM   = 1500;
    localparam int MAX_GAP    = 12;
    // Longest correct stretch with nothing accepted is one sender gap plus a
    // pipeline flush. The reset window counts as well. Take that many times over.
    localparam int IDLE_LIMIT = 8 * (LATENCY + MAX_GAP + RST_CYCLES);
    localparam int MAX_PRINTS = 40;

    localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_W);
    localparam logic [DATA_W-1:0] MOST_NEG  = DATA_W'(1) << (WORD_W - 1);
    localparam logic [DATA_W-1:0] MOST_POS  = MOST_NEG - 1;
    localparam logic [DATA_W-1:0] MINUS_ONE = WORD_MASK;

    // One accepted word together with the quotient and remainder it must produce.
    typedef struct {
        logic              op;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } t_div_result;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              i_operation = OP_UNSIGNED;
    logic [DATA_W-1:0] i_dividend  = '0;
    logic [DATA_W-1:0] i_divisor   = '0;
    logic              busy;
    logic              o_done;
    logic [DATA_W-1:0] o_quotient;
    logic [DATA_W-1:0] o_remainder;

    t_div_result pending_q[$];

    int n_errors    = 0;
    int n_accepted  = 0;
    int n_signed    = 0;
    int n_zero_div  = 0;
    int n_checked   = 0;
    int idle_cycles = 0;
    int burst_left  = 0;

    signed_unsigned_divider_64 #(
        .HALF_WIDTH (HALF_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_done      (o_done),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: restoring division of the magnitudes, one bit per step,
    // MSB first, then sign fix-up. Truncates toward zero. A zero divisor
    // falls out of the loop as an all-ones quotient magnitude (before the sign fix-up), remainder = dividend.
    // ------------------------------------------------------------------
    function automatic t_div_result divide_word(input logic op,
                                                input logic [DATA_W-1:0] num,
                                                input logic [DATA_W-1:0] den);
        t_div_result       res;
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
        logic              num_neg;
        logic              den_neg;
        logic              carry;
        res.op       = op;
        res.dividend = num;
        res.divisor  = den;
        mag_n   = num & WORD_MASK;
        mag_d   = den & WORD_MASK;
        num_neg = 1'b0;
        den_neg = 1'b0;
        if (op == OP_SIGNED) begin
            num_neg = mag_n[WORD_W-1];
            den_neg = mag_d[WORD_W-1];
            if (num_neg) mag_n = (-mag_n) & WORD_MASK;
            if (den_neg) mag_d = (-mag_d) & WORD_MASK;
        end
        quo = '0;
        rem = '0;
        for (int bit_idx = WORD_W - 1; bit_idx >= 0; bit_idx--) begin
            // bit shifted out of the partial remainder forces a subtract
            carry = rem[DATA_W-1];
            rem   = {rem[DATA_W-2:0], mag_n[bit_idx]};
            quo   = {quo[DATA_W-2:0], 1'b0};
            if (carry || rem >= mag_d) begin
                rem    = rem - mag_d;
                quo[0] = 1'b1;
            end
        end
        if (op == OP_SIGNED) begin
            if (num_neg != den_neg) quo = -quo;
            if (num_neg) rem = -rem;
        end
        res.quotient  = quo & WORD_MASK;
        res.remainder = rem & WORD_MASK;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Monitor and checker. Everything is sampled at the rising edge, so
    // the values seen are the ones the DUT itself sees on that edge.
    // The result is checked before the new word is queued; as the divider
    // registers every word, they can never refer to the same entry anyway.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_div_result exp_res;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (pending_q.size() == 0) begin
                    report_mismatch($sformatf("result with no word pending: q=%h r=%h",
                                              o_quotient, o_remainder));
                end else begin
                    exp_res = pending_q.pop_front();
                    n_checked++;
                    if (o_quotient !== exp_res.quotient)
                        report_mismatch($sformatf(
                            "quotient op=%0d %h / %h: got %h want %h", exp_res.op,
                            exp_res.dividend, exp_res.divisor, o_quotient,
                            exp_res.quotient));
                    if (o_remainder !== exp_res.remainder)
                        report_mismatch($sformatf(
                            "remainder op=%0d %h / %h: got %h want %h", exp_res.op,
                            exp_res.dividend, exp_res.divisor, o_remainder,
                            exp_res.remainder));
                end
            end
            if (start === 1'b1 && busy !== 1'b1) begin
                pending_q.push_back(divide_word(i_operation, i_dividend, i_divisor));
                n_accepted++;
                if (i_operation == OP_SIGNED) n_signed++;
                if ((i_divisor & WORD_MASK) == '0) n_zero_div++;
            end
        end
    end

    // Watchdog: any edge that moves a word in either direction resets it.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy !== 1'b1) || o_done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] ERROR: watchdog, no traffic for %0d cycles, %0d pending",
                     $time, idle_cycles, pending_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Called on a rising edge; drives the word, holds it until the
    // edge that accepts it, then either runs straight on (burst) or drops
    // start for a random gap with junk on the operand ports.
    // ------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic op, input logic [DATA_W-1:0] num,
                             input logic [DATA_W-1:0] den);
        start       <= 1'b1;
        i_operation <= op;
        i_dividend  <= num;
        i_divisor   <= den;
        @(posedge i_clk);
        while (busy === 1'b1) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start       <= 1'b0;
            i_operation <= 1'($urandom);
            i_dividend  <= rand_word();
            i_divisor   <= rand_word();
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
            // mostly short bursts, now and then a long back-to-back stretch
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Signed helper: negate within the data width.
    function automatic logic [DATA_W-1:0] neg_word(input logic [DATA_W-1:0] val);
        return (-val) & WORD_MASK;
    endfunction

    // Interesting boundary values for the random mix.
    function automatic logic [DATA_W-1:0] edge_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DATA_W'(1);
            2:       return MINUS_ONE;
            3:       return MOST_NEG;
            4:       return MOST_POS;
            5:       return MOST_NEG + 1;
            6:       return DATA_W'(2);
            default: return MINUS_ONE - 1;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_unsigned_extremes();
        send_word(OP_UNSIGNED, '0, DATA_W'(1));
        send_word(OP_UNSIGNED, MINUS_ONE, DATA_W'(1));
        send_word(OP_UNSIGNED, MINUS_ONE, MINUS_ONE);
        send_word(OP_UNSIGNED, '0, MINUS_ONE);
        send_word(OP_UNSIGNED, DATA_W'(1), MINUS_ONE);
        send_word(OP_UNSIGNED, MINUS_ONE, DATA_W'(2));
        send_word(OP_UNSIGNED, 64'h1234_5678_9abc_def0, DATA_W'(16));
        send_word(OP_UNSIGNED, DATA_W'(5), DATA_W'(7));
        // top bit set: unsigned must not treat it as a sign
        send_word(OP_UNSIGNED, MOST_NEG, DATA_W'(3));
    endtask

    task automatic test_signed_truncation();
        send_word(OP_SIGNED, neg_word(7), DATA_W'(2));
        send_word(OP_SIGNED, DATA_W'(7), neg_word(2));
        send_word(OP_SIGNED, neg_word(7), neg_word(2));
        send_word(OP_SIGNED, MOST_NEG, DATA_W'(1));
        send_word(OP_SIGNED, MOST_POS, MINUS_ONE);
        send_word(OP_SIGNED, MOST_NEG, MOST_NEG);
        send_word(OP_SIGNED, MINUS_ONE, MOST_POS);
    endtask

    task automatic test_divide_by_zero();
        send_word(OP_UNSIGNED, DATA_W'(5), '0);
        send_word(OP_UNSIGNED, '0, '0);
        send_word(OP_UNSIGNED, MINUS_ONE, '0);
        send_word(OP_SIGNED, neg_word(5), '0);
        send_word(OP_SIGNED, DATA_W'(5), '0);
        send_word(OP_SIGNED, MOST_NEG, '0);
    endtask

    task automatic test_most_negative_by_minus_one();
        // signed: quotient wraps to the most negative value, remainder zero
        send_word(OP_SIGNED, MOST_NEG, MINUS_ONE);
        send_word(OP_UNSIGNED, MOST_NEG, MINUS_ONE);
    endtask

    task automatic test_random_mix();
        logic              op;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        for (int k = 0; k < N_RANDOM; k++) begin
            op  = 1'($urandom);
            num = rand_word();
            den = rand_word();
            case ($urandom_range(0, 19)) inside
                [0:5]: ;            // full-width random operands
                [6:7]: begin        // small divisor, long quotient
                    den = DATA_W'($urandom_range(1, 255));
                    if (op == OP_SIGNED && $urandom_range(0, 1)) den = neg_word(den);
                end
                [8:10]: begin       // spread magnitudes on both sides
                    num = num >> $urandom_range(0, WORD_W - 1);
                    den = den >> $urandom_range(0, WORD_W - 1);
                    if (op == OP_SIGNED && $urandom_range(0, 1)) num = neg_word(num);
                    if (op == OP_SIGNED && $urandom_range(0, 1)) den = neg_word(den);
                end
                11: den = '0;
                [12:13]: begin
                    num = edge_word();
                    den = edge_word();
                end
                14: den = edge_word();
                15: num = edge_word();
                16: den = num;
                17: begin           // exact multiple, plus or minus a little
                    den = rand_word() >> $urandom_range(WORD_W / 2, WORD_W - 1);
                    num = den * DATA_W'($urandom) + DATA_W'($urandom_range(0, 2))
                          - DATA_W'(1);
                end
                18: begin
                    op  = OP_SIGNED;
                    num = MOST_NEG;
                    den = MINUS_ONE;
                end
                default: den = num + DATA_W'(1);
            endcase
            send_word(op, num, den);
        end
    endtask

    // Drop start, let the pipeline drain, then allow a full latency more
    // so a stray extra strobe would still be caught.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        while (pending_q.size() != 0) begin
            t_div_result left = pending_q.pop_front();
            report_mismatch($sformatf("no result for op=%0d %h / %h", left.op,
                                      left.dividend, left.divisor));
        end
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(0, 8);

        test_unsigned_extremes();
        test_signed_truncation();
        test_divide_by_zero();
        test_most_negative_by_minus_one();
        test_random_mix();
        drain_pipeline();

        $display("Run covered %0d words (%0d signed, %0d by zero), %0d results checked.",
                 n_accepted, n_signed, n_zero_div, n_checked);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/sud64_pkg.sv
src/sud64_prep.sv
src/sud64_cell.sv
src/sud64_post.sv
src/signed_unsigned_divider_64.sv
test/tb_top.sv
